// ===== rtl/m2h_pkg.sv =====
`default_nettype none

package m2h_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned VB_W   = 3;

    localparam logic [WORD_W-1:0] MIX_MUL    = 32'h5bd1e995;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'h9747b28c;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam logic [VB_W-1:0] VB_FULL = 3'd4;
    localparam logic [VB_W-1:0] VB_NONE = 3'd0;

    // Operand selection for the shared multiplier.
    typedef enum logic [2:0] {
        OP_K1   = 3'd0,
        OP_K2   = 3'd1,
        OP_H    = 3'd2,
        OP_TAIL = 3'd3,
        OP_FIN  = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        logic    step;
        mul_op_t op;
    } m2h_cmd_t;

    typedef struct packed {
        logic in_full;
        logic in_tail;
        logic item_last;
        logic out_free;
    } m2h_status_t;

    // Mask that keeps the low bytes of a short last word.
    function automatic logic [WORD_W-1:0] byte_mask(input logic [VB_W-1:0] vb);
        logic [WORD_W-1:0] m;
        begin
            case (vb)
                3'd0:    m = 32'h0000_0000;
                3'd1:    m = 32'h0000_00ff;
                3'd2:    m = 32'h0000_ffff;
                3'd3:    m = 32'h00ff_ffff;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/m2h_ifs.sv =====
`default_nettype none

interface m2h_key_if;
    logic                        valid;
    logic                        ready;
    logic [m2h_pkg::WORD_W-1:0]  key_word;
    logic [m2h_pkg::VB_W-1:0]    valid_bytes;
    logic                        first_word;
    logic                        last_word;
    logic [m2h_pkg::WORD_W-1:0]  key_length;

    modport source (output valid, key_word, valid_bytes, first_word, last_word, key_length,
                    input ready);
    modport sink   (input valid, key_word, valid_bytes, first_word, last_word, key_length,
                    output ready);
endinterface

interface m2h_hash_if;
    logic                        valid;
    logic                        ready;
    logic [m2h_pkg::WORD_W-1:0]  digest;
    logic                        length_error;

    modport source (output valid, digest, length_error, input ready);
    modport sink   (input valid, digest, length_error, output ready);
endinterface

interface m2h_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [m2h_pkg::WORD_W-1:0]  hash_seed;

    modport source (output valid, hash_seed, input ready);
    modport sink   (input valid, hash_seed, output ready);
endinterface

`default_nettype wire

// ===== rtl/murmur2_hash32_stream.sv =====
// A word is taken only in the idle state. A full word runs the K1, K2 and H steps,
// a last full word then adds FIN, a short last word runs TAIL then FIN and an
// empty last word runs FIN alone; FIN waits while the output register is full.
// The one shared multiplier sets this pace. A result waits in the output register while the next words are taken.
// Reset clears the hash, the length and byte counters, and loads the seed.
`default_nettype none

module murmur2_hash32_stream (
    input wire logic  clk,
    input wire logic  rst_n,
    m2h_key_if.sink   key,
    m2h_hash_if.source hash,
    m2h_cfg_if.sink   cfg
);
    import m2h_pkg::*;

    m2h_cmd_t    cmd;
    m2h_status_t status;
    logic        key_ready;
    logic        out_valid;
    logic        cfg_write;

    assign key.ready = key_ready;
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;
    assign hash.valid = out_valid;

    m2h_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (key.valid),
        .in_ready (key_ready),
        .status   (status),
        .cmd      (cmd)
    );

    m2h_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .key_word     (key.key_word),
        .valid_bytes  (key.valid_bytes),
        .first_word   (key.first_word),
        .last_word    (key.last_word),
        .key_length   (key.key_length),
        .cfg_write    (cfg_write),
        .cfg_seed     (cfg.hash_seed),
        .out_valid    (out_valid),
        .out_ready    (hash.ready),
        .digest       (hash.digest),
        .length_error (hash.length_error)
    );

endmodule

`default_nettype wire

// ===== rtl/m2h_ctrl.sv =====
`default_nettype none

module m2h_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire m2h_pkg::m2h_status_t status,
    output m2h_pkg::m2h_cmd_t         cmd
);
    import m2h_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_K1   = 6'b000010,
        ST_K2   = 6'b000100,
        ST_H    = 6'b001000,
        ST_TAIL = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.step   = 1'b0;
        cmd.op     = OP_K1;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (status.in_full)
                        state_next = ST_K1;
                    else if (status.in_tail)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_K1:
            begin
                cmd.step   = 1'b1;
                cmd.op     = OP_K1;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                cmd.step   = 1'b1;
                cmd.op     = OP_K2;
                state_next = ST_H;
            end
            ST_H:
            begin
                cmd.step   = 1'b1;
                cmd.op     = OP_H;
                state_next = status.item_last ? ST_FIN : ST_IDLE;
            end
            ST_TAIL:
            begin
                cmd.step   = 1'b1;
                cmd.op     = OP_TAIL;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // The result waits here until the output register can take it.
                cmd.op = OP_FIN;
                if (status.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/m2h_datapath.sv =====
`default_nettype none

module m2h_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire m2h_pkg::m2h_cmd_t             cmd,
    output m2h_pkg::m2h_status_t               status,
    input  wire logic [m2h_pkg::WORD_W-1:0]    key_word,
    input  wire logic [m2h_pkg::VB_W-1:0]      valid_bytes,
    input  wire logic                          first_word,
    input  wire logic                          last_word,
    input  wire logic [m2h_pkg::WORD_W-1:0]    key_length,
    input  wire logic                          cfg_write,
    input  wire logic [m2h_pkg::WORD_W-1:0]    cfg_seed,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [m2h_pkg::WORD_W-1:0]         digest,
    output logic                               length_error
);
    import m2h_pkg::*;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] hash_reg,  hash_next;
    logic [WORD_W-1:0] decl_reg,  decl_next;
    logic [WORD_W-1:0] bytes_reg, bytes_next;
    logic              last_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] k_reg;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_hash_reg;
    logic              out_err_reg;

    logic [VB_W-1:0]   vb_sat;
    logic [WORD_W-1:0] bytes_base;
    logic [WORD_W-1:0] bytes_add;
    logic [WORD_W-1:0] mul_in;
    logic [WORD_W-1:0] prod;
    logic              fin_write;

    // Counts above four are treated as a full word.
    assign vb_sat = (valid_bytes > VB_FULL) ? VB_FULL : valid_bytes;

    assign status.in_full   = !last_word || (vb_sat == VB_FULL);
    assign status.in_tail   = last_word && (vb_sat != VB_FULL) && (vb_sat != VB_NONE);
    assign status.item_last = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign bytes_base = first_word ? '0 : bytes_reg;
    assign bytes_add  = last_word ? {{(WORD_W-VB_W){1'b0}}, vb_sat} : WORD_W'(4);

    always_comb
    begin
        case (cmd.op)
            OP_K1:   mul_in = word_reg;
            OP_K2:   mul_in = k_reg ^ (k_reg >> MIX_SHIFT);
            OP_H:    mul_in = hash_reg;
            OP_TAIL: mul_in = hash_reg ^ word_reg;
            OP_FIN:  mul_in = hash_reg ^ (hash_reg >> FIN_SHIFT_A);
            default: mul_in = hash_reg;
        endcase
    end

    // One shared 32x32 multiplier, low half of the product only.
    assign prod      = mul_in * MIX_MUL;
    assign fin_write = cmd.step && (cmd.op == OP_FIN);

    always_comb
    begin
        hash_next  = hash_reg;
        decl_next  = decl_reg;
        bytes_next = bytes_reg;
        if (cmd.accept)
        begin
            if (first_word)
            begin
                hash_next = seed_reg ^ key_length;
                decl_next = key_length;
            end
            bytes_next = bytes_base + bytes_add;
        end
        else if (cmd.step && (cmd.op == OP_H))
            hash_next = prod ^ k_reg;
        else if (cmd.step && (cmd.op == OP_TAIL))
            hash_next = prod;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_write)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RESET;
            hash_reg      <= '0;
            decl_reg      <= '0;
            bytes_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                seed_reg <= cfg_seed;
            hash_reg      <= hash_next;
            decl_reg      <= decl_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
                last_reg <= last_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            word_reg <= last_word ? (key_word & byte_mask(vb_sat)) : key_word;
        if (cmd.step && ((cmd.op == OP_K1) || (cmd.op == OP_K2)))
            k_reg <= prod;
        if (fin_write)
        begin
            out_hash_reg <= prod ^ (prod >> FIN_SHIFT_B);
            out_err_reg  <= (bytes_reg != decl_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign digest       = out_hash_reg;
    assign length_error = out_err_reg;

endmodule

`default_nettype wire
